// ===== sv/rbcp_pkg.sv =====
// Shared constants, codes and types for the radial brush channel painter.
// Used by every module of the block; depends on nothing.
package rbcp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int unsigned MAX_DIM = 4096;

  localparam int COORD_W = 12;
  localparam int POS_W = 21;
  localparam int RADIUS_W = 20;
  localparam int POWER_W = 17;
  localparam int PIXEL_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int ROOT_W = RADIUS_W;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int QUOT_W = 9;
  localparam int PROD_W = POWER_W + RADIUS_W + 1;
  localparam int MAG_W = PROD_W - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 3'd4;

  localparam logic [1:0] CH_BLUE = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_z;
    logic [RADIUS_W-1:0] radius;
    logic signed [POWER_W-1:0] power;
    logic [1:0] channel;
  } rbcp_cfg_t;

  typedef struct packed {
    logic in_brush;
    logic [PIXEL_W-1:0] pixel;
  } rbcp_tag_t;

endpackage

// ===== sv/rbcp_front.sv =====
// Front stages: offsets from the brush center, squares and the inside test.
// Three register stages; depends on rbcp_pkg.
module rbcp_front
  import rbcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  rbcp_cfg_t cfg,
  input  logic in_valid,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [PIXEL_W-1:0] in_pixel,
  output logic out_valid,
  output rbcp_tag_t out_tag,
  output logic [RAD_W-1:0] out_d2
);

  logic s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic [POS_W-1:0] s1_adx_r;
  logic [POS_W-1:0] s1_adz_r;
  logic s1_bnd_r;

  logic s2_valid_r;
  logic [PIXEL_W-1:0] s2_pixel_r;
  logic [2*POS_W-1:0] s2_sqx_r;
  logic [2*POS_W-1:0] s2_sqz_r;
  logic [RAD_W-1:0] s2_r2_r;
  logic s2_bnd_r;

  logic s3_valid_r;
  rbcp_tag_t s3_tag_r;
  logic [RAD_W-1:0] s3_d2_r;

  logic signed [POS_W:0] dx;
  logic signed [POS_W:0] dz;
  logic signed [POS_W:0] sx;
  logic signed [POS_W:0] sz;
  logic bx;
  logic bz;
  logic [2*POS_W:0] d2;
  logic inside_nxt;

  always_comb begin
    dx = $signed({2'b00, in_x, {FRAC_BITS{1'b0}}}) - $signed({cfg.center_x[POS_W-1], cfg.center_x});
    dz = $signed({2'b00, in_y, {FRAC_BITS{1'b0}}}) - $signed({cfg.center_z[POS_W-1], cfg.center_z});
    sx = $signed({cfg.center_x[POS_W-1], cfg.center_x}) + $signed({2'b00, cfg.radius});
    sz = $signed({cfg.center_z[POS_W-1], cfg.center_z}) + $signed({2'b00, cfg.radius});
    bx = (sx > 0) && (32'(in_x) < MAX_DIM) && ({2'b00, in_x} < sx[POS_W:FRAC_BITS]);
    bz = (sz > 0) && (32'(in_y) < MAX_DIM) && ({2'b00, in_y} < sz[POS_W:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    s1_pixel_r <= in_pixel;
    s1_adx_r <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    s1_adz_r <= dz[POS_W] ? POS_W'(-dz) : dz[POS_W-1:0];
    s1_bnd_r <= bx && bz;

    s2_pixel_r <= s1_pixel_r;
    s2_sqx_r <= s1_adx_r * s1_adx_r;
    s2_sqz_r <= s1_adz_r * s1_adz_r;
    s2_r2_r <= cfg.radius * cfg.radius;
    s2_bnd_r <= s1_bnd_r;

    s3_tag_r.pixel <= s2_pixel_r;
    s3_tag_r.in_brush <= inside_nxt;
    s3_d2_r <= d2[RAD_W-1:0];
  end

  always_comb begin
    d2 = {1'b0, s2_sqx_r} + {1'b0, s2_sqz_r};
    inside_nxt = (cfg.radius != '0) && s2_bnd_r && (d2 <= {3'b000, s2_r2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_tag = s3_tag_r;
  assign out_d2 = s3_d2_r;

endmodule

// ===== sv/rbcp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage after the input register.
// Carries the pixel tag alongside; depends on rbcp_pkg.
module rbcp_sqrt
  import rbcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  rbcp_tag_t in_tag,
  input  logic [RAD_W-1:0] in_rad,
  output logic out_valid,
  output rbcp_tag_t out_tag,
  output logic [ROOT_W-1:0] out_root
);

  logic vld_r [0:ROOT_W];
  rbcp_tag_t tag_r [0:ROOT_W];
  logic [RAD_W-1:0] rad_r [0:ROOT_W];
  logic [ROOT_W:0] rem_r [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    rad_r[0] <= in_rad;
    rem_r[0] <= '0;
    root_r[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [ROOT_W+2:0] remx;
    logic [ROOT_W+2:0] trial;
    logic ge;
    logic [ROOT_W:0] rem_nxt;

    always_comb begin
      remx = {rem_r[i], rad_r[i][RAD_W-1 -: 2]};
      trial = {1'b0, root_r[i], 2'b01};
      ge = (remx >= trial);
      rem_nxt = ge ? (ROOT_W+1)'(remx - trial) : remx[ROOT_W:0];
    end

    always_ff @(posedge clk) begin
      tag_r[i+1] <= tag_r[i];
      rad_r[i+1] <= {rad_r[i][RAD_W-3:0], 2'b00};
      rem_r[i+1] <= rem_nxt;
      root_r[i+1] <= {root_r[i][ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_tag = tag_r[ROOT_W];
  assign out_root = root_r[ROOT_W];

endmodule

// ===== sv/rbcp_div.sv =====
// Falloff product, pipelined restoring divide by the scaled radius, and the
// saturating byte update. Depends on rbcp_pkg.
module rbcp_div
  import rbcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  rbcp_cfg_t cfg,
  input  logic in_valid,
  input  rbcp_tag_t in_tag,
  input  logic [ROOT_W-1:0] in_root,
  output logic out_valid,
  output logic [PIXEL_W-1:0] out_pixel,
  output logic out_touched
);

  logic m_valid_r;
  rbcp_tag_t m_tag_r;
  logic [7:0] m_old_r;
  logic signed [PROD_W-1:0] m_prod_r;

  logic vld_r [0:QUOT_W];
  rbcp_tag_t tag_r [0:QUOT_W];
  logic [7:0] old_r [0:QUOT_W];
  logic neg_r [0:QUOT_W];
  logic [MAG_W-1:0] rem_r [0:QUOT_W];
  logic [QUOT_W-1:0] quo_r [0:QUOT_W];

  logic out_valid_r;
  logic [PIXEL_W-1:0] out_pixel_r;
  logic out_touched_r;

  logic signed [RADIUS_W:0] rd;
  logic [7:0] old_byte;
  logic nz;
  logic [QUOT_W:0] qmag;
  logic signed [QUOT_W+1:0] qs;
  logic signed [QUOT_W+1:0] val;
  logic [7:0] nb;
  logic [PIXEL_W-1:0] pix_nxt;

  always_comb begin
    rd = $signed({1'b0, cfg.radius}) - $signed({1'b0, in_root});
    case (cfg.channel)
      CH_BLUE: old_byte = in_tag.pixel[7:0];
      CH_GREEN: old_byte = in_tag.pixel[15:8];
      CH_RED: old_byte = in_tag.pixel[23:16];
      CH_ALPHA: old_byte = in_tag.pixel[31:24];
      default: old_byte = in_tag.pixel[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    m_tag_r <= in_tag;
    m_old_r <= old_byte;
    m_prod_r <= cfg.power * rd;

    tag_r[0] <= m_tag_r;
    old_r[0] <= m_old_r;
    neg_r[0] <= m_prod_r[PROD_W-1];
    rem_r[0] <= m_prod_r[PROD_W-1] ? MAG_W'(-m_prod_r) : m_prod_r[MAG_W-1:0];
    quo_r[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
      vld_r[0] <= m_valid_r;
    end
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
    logic [MAG_W-1:0] dsh;
    logic ge;

    always_comb begin
      dsh = MAG_W'(cfg.radius) << (FRAC_BITS + QUOT_W - 1 - j);
      ge = (rem_r[j] >= dsh);
    end

    always_ff @(posedge clk) begin
      tag_r[j+1] <= tag_r[j];
      old_r[j+1] <= old_r[j];
      neg_r[j+1] <= neg_r[j];
      rem_r[j+1] <= ge ? (rem_r[j] - dsh) : rem_r[j];
      quo_r[j+1] <= {quo_r[j][QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end
  end

  always_comb begin
    nz = neg_r[QUOT_W] && (rem_r[QUOT_W] != '0);
    qmag = {1'b0, quo_r[QUOT_W]} + {{QUOT_W{1'b0}}, nz};
    qs = neg_r[QUOT_W] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    val = $signed({{(QUOT_W-6){1'b0}}, old_r[QUOT_W]}) + qs;
    if (val[QUOT_W+1]) begin
      nb = 8'h00;
    end else if (val > $signed((QUOT_W+2)'(255))) begin
      nb = 8'hFF;
    end else begin
      nb = val[7:0];
    end
    pix_nxt = tag_r[QUOT_W].pixel;
    if (tag_r[QUOT_W].in_brush) begin
      case (cfg.channel)
        CH_BLUE: pix_nxt[7:0] = nb;
        CH_GREEN: pix_nxt[15:8] = nb;
        CH_RED: pix_nxt[23:16] = nb;
        CH_ALPHA: pix_nxt[31:24] = nb;
        default: pix_nxt[7:0] = nb;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r <= pix_nxt;
    out_touched_r <= tag_r[QUOT_W].in_brush;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[QUOT_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_touched = out_touched_r;

endmodule

// ===== sv/radial_brush_channel_paint.sv =====
// Radial brush with linear falloff on one byte of a BGRA pixel stream.
// Throughput: one pixel per cycle; busy stays low and the receiver cannot stall.
// The pipeline runs through the front stages, the 20-stage square root and the 9-stage divider.
// Reset (rst_n low, synchronous) clears the brush registers to zero and empties the pipeline.
module radial_brush_channel_paint
  import rbcp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [COORD_W-1:0] in_pixel_x,
  input  logic [COORD_W-1:0] in_pixel_y,
  input  logic [PIXEL_W-1:0] in_pixel_in,
  output logic out_valid,
  output logic [PIXEL_W-1:0] out_pixel_out,
  output logic out_touched,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rbcp_cfg_t cfg_r;
  rbcp_cfg_t cfg_nxt;

  logic fr_valid;
  rbcp_tag_t fr_tag;
  logic [RAD_W-1:0] fr_d2;
  logic sq_valid;
  rbcp_tag_t sq_tag;
  logic [ROOT_W-1:0] sq_root;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTER_X: cfg_nxt.center_x = cfg_data[POS_W-1:0];
        CFG_CENTER_Z: cfg_nxt.center_z = cfg_data[POS_W-1:0];
        CFG_RADIUS: cfg_nxt.radius = cfg_data[RADIUS_W-1:0];
        CFG_POWER: cfg_nxt.power = cfg_data[POWER_W-1:0];
        CFG_CHANNEL: cfg_nxt.channel = cfg_data[1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbcp_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_valid(start && !busy),
    .in_x(in_pixel_x),
    .in_y(in_pixel_y),
    .in_pixel(in_pixel_in),
    .out_valid(fr_valid),
    .out_tag(fr_tag),
    .out_d2(fr_d2)
  );

  rbcp_sqrt u_sqrt (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(fr_valid),
    .in_tag(fr_tag),
    .in_rad(fr_d2),
    .out_valid(sq_valid),
    .out_tag(sq_tag),
    .out_root(sq_root)
  );

  rbcp_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .in_valid(sq_valid),
    .in_tag(sq_tag),
    .in_root(sq_root),
    .out_valid(out_valid),
    .out_pixel(out_pixel_out),
    .out_touched(out_touched)
  );

endmodule
